/* hw/rtl/emrg_pkg.sv */
// Shared types and constants of the maze row generator.
package emrg_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int LABEL_BITS  = 17;

    localparam int ROW_W       = 10;
    localparam int ROWS_W      = 11;
    localparam int COLS_W      = 7;
    localparam int WALL_W      = 64;
    localparam int MERGE_W     = 63;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd10;
    localparam logic [COLS_W-1:0] COLS_RESET = 7'd10;
    localparam logic [ROWS_W-1:0] ROWS_LIMIT = 11'd1024;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAZE_ROWS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAZE_COLS = 1'b1;

    typedef struct packed {
        logic load;
        logic merge_step;
        logic down_step;
        logic finish;
    } emrg_cmd_t;

    typedef struct packed {
        logic step_last;
        logic out_free;
    } emrg_status_t;

endpackage

/* hw/rtl/emrg_ctrl.sv */
// Sequencer for one row: load, merge pass, downward pass, output write.
module emrg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  emrg_pkg::emrg_status_t status,
    output emrg_pkg::emrg_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_DOWN,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;

    assign in_ready = in_ready_reg;

    always_comb
    begin
        cmd.load       = in_valid && in_ready_reg;
        cmd.merge_step = (state_reg == ST_MERGE);
        cmd.down_step  = (state_reg == ST_DOWN);
        cmd.finish     = (state_reg == ST_DONE) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready_reg)
                    begin
                        state_reg    <= ST_MERGE;
                        in_ready_reg <= 1'b0;
                    end
                end
                ST_MERGE:
                begin
                    if (status.step_last)
                    begin
                        state_reg <= ST_DOWN;
                    end
                end
                ST_DOWN:
                begin
                    if (status.step_last)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    // hold until the output register is free
                    if (status.out_free)
                    begin
                        state_reg    <= ST_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= ST_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_finish_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> in_ready)
        else $error("input not reopened after a row was written");
`endif

endmodule

/* hw/rtl/emrg_datapath.sv */
// Label lanes, wall shift registers, counters and output register.
module emrg_datapath #(
    parameter int MAX_COLUMNS = emrg_pkg::MAX_COLUMNS,
    parameter int LABEL_BITS  = emrg_pkg::LABEL_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [emrg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [emrg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 new_maze,
    input  logic [emrg_pkg::MERGE_W-1:0]         merge_random,
    input  logic [emrg_pkg::WALL_W-1:0]          down_random,
    input  emrg_pkg::emrg_cmd_t                  cmd,
    output emrg_pkg::emrg_status_t               status,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [emrg_pkg::ROW_W-1:0]           row_number,
    output logic [emrg_pkg::WALL_W-1:0]          right_walls,
    output logic [emrg_pkg::WALL_W-1:0]          bottom_walls,
    output logic                                 final_row
);

    localparam int SW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int SECOND = (MAX_COLUMNS > 1) ? 1 : 0;
    localparam logic [SW-1:0] LAST_STEP = SW'(MAX_COLUMNS - 1);
    localparam logic [emrg_pkg::COLS_W-1:0] N_COLS = emrg_pkg::COLS_W'(MAX_COLUMNS);

    logic [emrg_pkg::ROWS_W-1:0] maze_rows_reg;
    logic [emrg_pkg::ROWS_W-1:0] rows_used;
    logic [emrg_pkg::COLS_W-1:0] maze_cols_reg;
    logic [emrg_pkg::COLS_W-1:0] cols_used;

    logic [LABEL_BITS-1:0]  label_reg  [MAX_COLUMNS];
    logic [LABEL_BITS-1:0]  label_next [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0] use_reg;
    logic [MAX_COLUMNS-1:0] use_next;
    logic [MAX_COLUMNS-1:0] right_reg;
    logic [MAX_COLUMNS-1:0] right_next;
    logic [MAX_COLUMNS-1:0] bottom_reg;
    logic [MAX_COLUMNS-1:0] bottom_next;

    logic [LABEL_BITS-1:0]  label_counter_reg;
    logic [LABEL_BITS-1:0]  label_counter_next;
    logic [LABEL_BITS-1:0]  fresh;
    logic [LABEL_BITS-1:0]  lane0;
    logic [LABEL_BITS-1:0]  lane1;

    logic [emrg_pkg::ROW_W-1:0] current_row_reg;
    logic [emrg_pkg::ROW_W-1:0] current_row_next;
    logic [emrg_pkg::ROW_W-1:0] row_start;
    logic [emrg_pkg::ROW_W-1:0] row_num_reg;

    logic [SW-1:0]               step_reg;
    logic [SW-1:0]               step_next;
    logic [emrg_pkg::COLS_W-1:0] step_col;
    logic [emrg_pkg::WALL_W-1:0] merge_reg;
    logic [emrg_pkg::WALL_W-1:0] down_reg;

    logic last_reg;
    logic last_start;
    logic need_down_reg;
    logic need_down_next;
    logic do_merge;
    logic wall_bit;
    logic in_col;
    logic cur_wall;
    logic open_down;

    logic                        out_valid_reg;
    logic [emrg_pkg::ROW_W-1:0]  out_row_reg;
    logic [emrg_pkg::WALL_W-1:0] out_right_reg;
    logic [emrg_pkg::WALL_W-1:0] out_bottom_reg;
    logic                        out_final_reg;

    // clamp configuration to the legal ranges
    always_comb
    begin
        if (maze_rows_reg == '0)
            rows_used = emrg_pkg::ROWS_W'(1);
        else if (maze_rows_reg > emrg_pkg::ROWS_LIMIT)
            rows_used = emrg_pkg::ROWS_LIMIT;
        else
            rows_used = maze_rows_reg;

        if (maze_cols_reg == '0)
            cols_used = emrg_pkg::COLS_W'(1);
        else if (maze_cols_reg > N_COLS)
            cols_used = N_COLS;
        else
            cols_used = maze_cols_reg;
    end

    assign row_start  = new_maze ? '0 : current_row_reg;
    assign last_start = ({1'b0, row_start} + emrg_pkg::ROWS_W'(1)) >= rows_used;

    // lane 0 always holds the column under work, lane 1 its right neighbor
    assign lane0    = label_reg[0];
    assign lane1    = label_reg[SECOND];
    assign step_col = emrg_pkg::COLS_W'(step_reg);
    assign in_col   = step_col < cols_used;
    assign do_merge = ((step_col + emrg_pkg::COLS_W'(1)) < cols_used) && (lane0 != lane1)
                      && (last_reg || merge_reg[step_reg]);
    assign wall_bit = in_col && !do_merge;
    assign cur_wall = right_reg[step_reg];
    assign open_down = in_col && !last_reg
                       && ((!cur_wall && down_reg[step_reg]) || (cur_wall && need_down_reg));
    assign fresh    = label_counter_reg + LABEL_BITS'(1);

    assign status.step_last = (step_reg == LAST_STEP);
    assign status.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        label_next         = label_reg;
        use_next           = use_reg;
        right_next         = right_reg;
        bottom_next        = bottom_reg;
        label_counter_next = label_counter_reg;
        current_row_next   = current_row_reg;
        step_next          = step_reg;
        need_down_next     = need_down_reg;

        if (cmd.load)
        begin
            if (new_maze)
            begin
                for (int p = 0; p < MAX_COLUMNS; p++)
                begin
                    if (emrg_pkg::COLS_W'(p) < cols_used)
                        label_next[p] = LABEL_BITS'(p + 1);
                end
                label_counter_next = LABEL_BITS'(cols_used);
                current_row_next   = '0;
            end
            for (int p = 0; p < MAX_COLUMNS; p++)
            begin
                use_next[p] = emrg_pkg::COLS_W'(p) < cols_used;
            end
            step_next      = '0;
            need_down_next = 1'b1;
            right_next     = '0;
            bottom_next    = '0;
        end
        else if (cmd.merge_step)
        begin
            // relabel every used lane of the right set and rotate by one
            for (int p = 0; p < MAX_COLUMNS; p++)
            begin
                if (do_merge && use_reg[(p + 1) % MAX_COLUMNS]
                    && (label_reg[(p + 1) % MAX_COLUMNS] == lane1))
                    label_next[p] = lane0;
                else
                    label_next[p] = label_reg[(p + 1) % MAX_COLUMNS];
                use_next[p] = use_reg[(p + 1) % MAX_COLUMNS];
            end
            right_next = (right_reg >> 1) | (MAX_COLUMNS'(wall_bit) << (MAX_COLUMNS - 1));
            step_next  = status.step_last ? '0 : step_reg + SW'(1);
        end
        else if (cmd.down_step)
        begin
            for (int p = 0; p < MAX_COLUMNS; p++)
            begin
                label_next[p] = label_reg[(p + 1) % MAX_COLUMNS];
            end
            // open cells keep their set, the rest draw a fresh label
            if (in_col && !last_reg && !open_down)
                label_next[MAX_COLUMNS-1] = fresh;
            else
                label_next[MAX_COLUMNS-1] = lane0;
            if (in_col && !last_reg)
                label_counter_next = fresh;
            if (in_col)
            begin
                if (cur_wall)
                    need_down_next = 1'b1;
                else if (open_down)
                    need_down_next = 1'b0;
            end
            bottom_next = (bottom_reg >> 1)
                          | (MAX_COLUMNS'(in_col && !open_down) << (MAX_COLUMNS - 1));
            step_next   = status.step_last ? '0 : step_reg + SW'(1);
        end
        else if (cmd.finish)
        begin
            if (!last_reg)
                current_row_next = row_num_reg + emrg_pkg::ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maze_rows_reg     <= emrg_pkg::ROWS_RESET;
            maze_cols_reg     <= emrg_pkg::COLS_RESET;
            label_counter_reg <= '0;
            current_row_reg   <= '0;
            step_reg          <= '0;
            need_down_reg     <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    emrg_pkg::CFG_MAZE_ROWS: maze_rows_reg <= cfg_data;
                    emrg_pkg::CFG_MAZE_COLS:
                        maze_cols_reg <= cfg_data[emrg_pkg::COLS_W-1:0];
                    default: ;
                endcase
            end
            label_counter_reg <= label_counter_next;
            current_row_reg   <= current_row_next;
            step_reg          <= step_next;
            need_down_reg     <= need_down_next;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        label_reg  <= label_next;
        use_reg    <= use_next;
        right_reg  <= right_next;
        bottom_reg <= bottom_next;
        if (cmd.load)
        begin
            merge_reg   <= {1'b0, merge_random};
            down_reg    <= down_random;
            row_num_reg <= row_start;
            last_reg    <= last_start;
        end
        if (cmd.finish)
        begin
            out_row_reg    <= row_num_reg;
            out_right_reg  <= emrg_pkg::WALL_W'(right_reg);
            out_bottom_reg <= emrg_pkg::WALL_W'(bottom_reg);
            out_final_reg  <= last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_number   = out_row_reg;
    assign right_walls  = out_right_reg;
    assign bottom_walls = out_bottom_reg;
    assign final_row    = out_final_reg;

`ifndef ASSERT_OFF
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("row written over a transaction still waiting");

    a_load_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (step_reg == '0))
        else $error("column counter not restarted at a new row");

    a_merge_wall: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.merge_step && do_merge) |-> !wall_bit)
        else $error("merged columns kept their wall");
`endif

endmodule

/* hw/rtl/eller_maze_row_generator_top.sv */
// Top level of the maze row generator: controller and datapath.
//
// Each input transaction (new_maze, merge_random, down_random) yields one row of
// the maze as one output transaction (row_number, right_walls, bottom_walls,
// final_row). new_maze restarts at row 0 with fresh set labels.
// maze_rows and maze_cols are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, which the block itself does not enforce.
// From acceptance to out_valid, the set labels rotate through lane 0 once for the
// merge pass and once for the downward pass, one column per cycle, and then the
// result is loaded into the output register; in_ready returns in the same cycle
// the result is loaded into the output register, so a new transaction is taken
// only after the previous row has been loaded there.
// The output register holds a finished row while the next transaction is taken;
// if out_ready stays low, the following row waits in the datapath and in_ready
// stays low until the output register frees up.
// Reset clears the row counter, label counter and all valid flags and loads the
// register defaults of 10 rows and 10 columns; labels are unknown until the first
// transaction with new_maze set.
module eller_maze_row_generator_top #(
    parameter int MAX_COLUMNS = emrg_pkg::MAX_COLUMNS,
    parameter int LABEL_BITS  = emrg_pkg::LABEL_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [emrg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [emrg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             new_maze,
    input  logic [emrg_pkg::MERGE_W-1:0]     merge_random,
    input  logic [emrg_pkg::WALL_W-1:0]      down_random,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [emrg_pkg::ROW_W-1:0]       row_number,
    output logic [emrg_pkg::WALL_W-1:0]      right_walls,
    output logic [emrg_pkg::WALL_W-1:0]      bottom_walls,
    output logic                             final_row
);

    emrg_pkg::emrg_cmd_t    cmd;
    emrg_pkg::emrg_status_t status;

    emrg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    emrg_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .LABEL_BITS  (LABEL_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .new_maze     (new_maze),
        .merge_random (merge_random),
        .down_random  (down_random),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .row_number   (row_number),
        .right_walls  (right_walls),
        .bottom_walls (bottom_walls),
        .final_row    (final_row)
    );

endmodule
